>>> rtl/core/chacha20_block_function_core_macros.svh
// Assertion macros used by the core's top-level RTL file.
`ifndef CHACHA20_BLOCK_FUNCTION_CORE_MACROS_SVH
`define CHACHA20_BLOCK_FUNCTION_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CC20BF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define CC20BF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/cc20bf_pkg.sv
`timescale 1ns / 1ps
package cc20bf_pkg;

  localparam int WORD_W  = 32;
  localparam int N_WORDS = 16;
  localparam int N_LANES = 4;

  // Right rotations of the quarter-round, equal to left rotations by 16, 12, 8 and 7.
  localparam int ROT_A = 16;
  localparam int ROT_B = 20;
  localparam int ROT_C = 24;
  localparam int ROT_D = 25;

  typedef logic [WORD_W-1:0]              word_t;
  typedef logic [2*WORD_W-1:0]            pair_t;
  typedef logic [N_WORDS-1:0][WORD_W-1:0] state_t;

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

endpackage

>>> rtl/core/cc20bf_ifs.sv
`timescale 1ns / 1ps
// Input block channel: sixteen state words, two to a field.
interface cc20bf_state_if;
  logic               valid;
  logic               ready;
  cc20bf_pkg::pair_t  state_w0_w1;
  cc20bf_pkg::pair_t  state_w2_w3;
  cc20bf_pkg::pair_t  state_w4_w5;
  cc20bf_pkg::pair_t  state_w6_w7;
  cc20bf_pkg::pair_t  state_w8_w9;
  cc20bf_pkg::pair_t  state_w10_w11;
  cc20bf_pkg::pair_t  state_w12_w13;
  cc20bf_pkg::pair_t  state_w14_w15;

  modport source (
    output valid, state_w0_w1, state_w2_w3, state_w4_w5, state_w6_w7,
           state_w8_w9, state_w10_w11, state_w12_w13, state_w14_w15,
    input  ready
  );
  modport sink (
    input  valid, state_w0_w1, state_w2_w3, state_w4_w5, state_w6_w7,
           state_w8_w9, state_w10_w11, state_w12_w13, state_w14_w15,
    output ready
  );
endinterface

// Keystream channel: sixteen keystream words, two to a field.
interface cc20bf_stream_if;
  logic               valid;
  logic               ready;
  cc20bf_pkg::pair_t  stream_w0_w1;
  cc20bf_pkg::pair_t  stream_w2_w3;
  cc20bf_pkg::pair_t  stream_w4_w5;
  cc20bf_pkg::pair_t  stream_w6_w7;
  cc20bf_pkg::pair_t  stream_w8_w9;
  cc20bf_pkg::pair_t  stream_w10_w11;
  cc20bf_pkg::pair_t  stream_w12_w13;
  cc20bf_pkg::pair_t  stream_w14_w15;

  modport source (
    output valid, stream_w0_w1, stream_w2_w3, stream_w4_w5, stream_w6_w7,
           stream_w8_w9, stream_w10_w11, stream_w12_w13, stream_w14_w15,
    input  ready
  );
  modport sink (
    input  valid, stream_w0_w1, stream_w2_w3, stream_w4_w5, stream_w6_w7,
           stream_w8_w9, stream_w10_w11, stream_w12_w13, stream_w14_w15,
    output ready
  );
endinterface

>>> rtl/core/cc20bf_qr.sv
`timescale 1ns / 1ps
// One quarter-round lane.
module cc20bf_qr (
  input  cc20bf_pkg::word_t a_in,
  input  cc20bf_pkg::word_t b_in,
  input  cc20bf_pkg::word_t c_in,
  input  cc20bf_pkg::word_t d_in,
  output cc20bf_pkg::word_t a_out,
  output cc20bf_pkg::word_t b_out,
  output cc20bf_pkg::word_t c_out,
  output cc20bf_pkg::word_t d_out
);
  import cc20bf_pkg::*;

  word_t a1, b1, c1, d1;
  word_t a2, b2, c2, d2;

  always_comb begin
    a1 = a_in + b_in;
    d1 = rotr(d_in ^ a1, ROT_A);
    c1 = c_in + d1;
    b1 = rotr(b_in ^ c1, ROT_B);
    a2 = a1 + b1;
    d2 = rotr(d1 ^ a2, ROT_C);
    c2 = c1 + d2;
    b2 = rotr(b1 ^ c2, ROT_D);
  end

  assign a_out = a2;
  assign b_out = b2;
  assign c_out = c2;
  assign d_out = d2;

endmodule

>>> rtl/core/cc20bf_merge.sv
`timescale 1ns / 1ps
// Feed-forward add of the final working state and the input block, into the keystream output register.
module cc20bf_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  cc20bf_pkg::state_t     fin,
  input  cc20bf_pkg::state_t     orig,
  output logic                   slot_free,
  cc20bf_stream_if.source        keystream
);
  import cc20bf_pkg::*;

  state_t sum;

  always_comb begin
    for (int i = 0; i < N_WORDS; i++) begin
      sum[i] = fin[i] + orig[i];
    end
  end

  // The register can take a new block when empty or when its content leaves now.
  assign slot_free = !keystream.valid || keystream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keystream.valid <= 1'b0;
    end else if (load) begin
      keystream.valid <= 1'b1;
    end else if (keystream.ready) begin
      keystream.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      keystream.stream_w0_w1   <= sum[1:0];
      keystream.stream_w2_w3   <= sum[3:2];
      keystream.stream_w4_w5   <= sum[5:4];
      keystream.stream_w6_w7   <= sum[7:6];
      keystream.stream_w8_w9   <= sum[9:8];
      keystream.stream_w10_w11 <= sum[11:10];
      keystream.stream_w12_w13 <= sum[13:12];
      keystream.stream_w14_w15 <= sum[15:14];
    end
  end

endmodule

>>> rtl/core/chacha20_block_function_core.sv
`timescale 1ns / 1ps
// Channel    | Role | Payload                               | Transfer when
// state      | sink | state_w0_w1 .. state_w14_w15, 8 x 64  | valid && ready
// keystream  | src  | stream_w0_w1 .. stream_w14_w15, 8 x 64 | valid && ready
//
// Each block runs one round per cycle, set by the single round register that the
// four quarter-round lanes share; the last round is held while the output stalls.
// The keystream is the last round's result plus the input copy, registered on load.
// Synchronous active-high reset empties the round engine and the output register.
// A new block is taken in the cycle the previous one moves into the output
// register; a stalled output holds the finished block in the engine.
module chacha20_block_function_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic             clk,
  input  logic             rst,
  cc20bf_state_if.sink     state,
  cc20bf_stream_if.source  keystream
);
  import cc20bf_pkg::*;

  `include "chacha20_block_function_core_macros.svh"

  localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int CNT_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUNDS - 1);

  // Working state, the copy of the input kept for the final add, and the
  // round counter. An even count is a column round, an odd one a diagonal round.
  state_t            work;
  state_t            orig;
  state_t            work_next;
  state_t            in_words;
  logic [CNT_W-1:0]  rnd;
  logic              busy;

  logic              last;
  logic              slot_free;
  logic              load;
  logic              accept;
  logic              diag;

  word_t qa_in  [N_LANES];
  word_t qb_in  [N_LANES];
  word_t qc_in  [N_LANES];
  word_t qd_in  [N_LANES];
  word_t qa_out [N_LANES];
  word_t qb_out [N_LANES];
  word_t qc_out [N_LANES];
  word_t qd_out [N_LANES];

  // Word 0 of the block lies in the low half of the first field.
  assign in_words = {state.state_w14_w15, state.state_w12_w13, state.state_w10_w11,
                     state.state_w8_w9, state.state_w6_w7, state.state_w4_w5,
                     state.state_w2_w3, state.state_w0_w1};

  assign diag   = rnd[0];
  assign last   = (rnd == LAST_RND);
  // The finished block moves to the output register when that register is free.
  assign load   = busy && last && slot_free;
  assign state.ready = !busy || load;
  assign accept = state.valid && state.ready;

  // Lane l always takes row 0 word l; in a diagonal round rows 1..3 are
  // shifted left by 1, 2 and 3 places.
  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    localparam int IB = N_LANES + ((l + 1) % N_LANES);
    localparam int IC = 2 * N_LANES + ((l + 2) % N_LANES);
    localparam int ID = 3 * N_LANES + ((l + 3) % N_LANES);

    assign qa_in[l] = work[l];
    assign qb_in[l] = diag ? work[IB] : work[N_LANES + l];
    assign qc_in[l] = diag ? work[IC] : work[2 * N_LANES + l];
    assign qd_in[l] = diag ? work[ID] : work[3 * N_LANES + l];

    cc20bf_qr u_qr (
      .a_in  (qa_in[l]),
      .b_in  (qb_in[l]),
      .c_in  (qc_in[l]),
      .d_in  (qd_in[l]),
      .a_out (qa_out[l]),
      .b_out (qb_out[l]),
      .c_out (qc_out[l]),
      .d_out (qd_out[l])
    );
  end

  // Put the lane results back in the places they were taken from.
  always_comb begin
    work_next = work;
    for (int l = 0; l < N_LANES; l++) begin
      work_next[l] = qa_out[l];
      if (diag) begin
        work_next[N_LANES + ((l + 1) % N_LANES)]     = qb_out[l];
        work_next[2 * N_LANES + ((l + 2) % N_LANES)] = qc_out[l];
        work_next[3 * N_LANES + ((l + 3) % N_LANES)] = qd_out[l];
      end else begin
        work_next[N_LANES + l]     = qb_out[l];
        work_next[2 * N_LANES + l] = qc_out[l];
        work_next[3 * N_LANES + l] = qd_out[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (busy && !last) begin
      rnd  <= rnd + CNT_W'(1);
    end else if (load) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work <= in_words;
      orig <= in_words;
    end else if (busy && !last) begin
      work <= work_next;
    end
  end

  // The last round feeds the merge stage directly, without a register between them.
  cc20bf_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .fin       (work_next),
    .orig      (orig),
    .slot_free (slot_free),
    .keystream (keystream)
  );

  `CC20BF_ASSERT_NEXT(a_round_step, busy && !last, busy && (rnd == $past(rnd) + CNT_W'(1)), "round counter did not advance")
  `CC20BF_ASSERT_NEXT(a_accept_start, accept, busy && (rnd == '0), "accepted block did not start at round zero")
  `CC20BF_ASSERT_NEXT(a_load_valid, load, keystream.valid, "finished block not presented")
  `CC20BF_ASSERT(a_ready_busy, !(state.ready && busy) || (last && slot_free), "input taken while rounds remain")

endmodule
